FILE: hw/rtl/srs_pkg.sv
// srs_pkg: shared types and constants for the servo recipe sequencer.
// Used by servo_recipe_sequencer and srs_checker; no dependencies.

package srs_pkg;

    localparam int RECIPE_DEPTH_DEF = 32;
    localparam int NUM_POS          = 6;
    localparam logic [2:0] LAST_POS = 3'd5;

    localparam int MODE_W  = 2;
    localparam int EVENT_W = 3;
    localparam int ADDR_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int PARAM_W = 5;
    localparam int OP_W    = 3;
    localparam int POS_W   = 3;
    localparam int DUTY_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int MOVE_W  = 3;

    // reset duty values, position 0 in the low byte
    localparam logic [NUM_POS-1:0][DUTY_W-1:0] DUTY_RESET =
        {8'd21, 8'd17, 8'd13, 8'd10, 8'd6, 8'd5};

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_EVENT = 2'd1,
        MODE_LOAD  = 2'd2
    } mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_BEGIN  = 3'd1,
        EV_PAUSE  = 3'd2,
        EV_RESUME = 3'd3,
        EV_LEFT   = 3'd4,
        EV_RIGHT  = 3'd5
    } event_t;

    // opcode field, bits 7:5 of a recipe byte
    typedef enum logic [OP_W-1:0] {
        OP_END     = 3'd0,
        OP_MOVE    = 3'd1,
        OP_WAIT    = 3'd2,
        OP_LOOP    = 3'd4,
        OP_ENDLOOP = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        RS_PAUSED   = 2'd0,
        RS_RUNNING  = 2'd1,
        RS_CMD_ERR  = 2'd2,
        RS_NEST_ERR = 2'd3
    } run_t;

    typedef enum logic [1:0] {
        MS_UNKNOWN = 2'd0,
        MS_AT_POS  = 2'd1,
        MS_MOVING  = 2'd2,
        MS_ENDED   = 2'd3
    } motion_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_POS0 = 3'd0,
        REG_DUTY_POS1 = 3'd1,
        REG_DUTY_POS2 = 3'd2,
        REG_DUTY_POS3 = 3'd3,
        REG_DUTY_POS4 = 3'd4,
        REG_DUTY_POS5 = 3'd5
    } cfg_idx_t;

endpackage

FILE: hw/rtl/servo_recipe_sequencer.sv
// servo_recipe_sequencer: recipe interpreter for one servo channel.
// Depends on srs_pkg (types, opcodes, status codes, reset duty values).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | to block  | in_valid/in_ready   | mode, event_code, load_addr, load_data
//   out     | from blk  | out_valid/out_ready | duty_value, duty_update, servo_position,
//           |           |                     | servo_status, recipe_status
//   cfg     | to block  | cfg_we              | cfg_index, cfg_data
//
// One item per cycle while no result is stalled: the state update and result are formed
// in the accept cycle and the result shows in the output register on the next cycle.
// The recipe byte at the current step is prefetched into a read register from the
// recipe memory, addressed by the next step index, so a tick never waits on the RAM.
// in_ready drops only while a result is held and out_ready is low.
// rst_n clears all control state; the recipe memory has no reset.

module servo_recipe_sequencer #(
    parameter int RECIPE_DEPTH = srs_pkg::RECIPE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [srs_pkg::MODE_W-1:0]    mode,
    input  logic [srs_pkg::EVENT_W-1:0]   event_code,
    input  logic [srs_pkg::ADDR_W-1:0]    load_addr,
    input  logic [srs_pkg::BYTE_W-1:0]    load_data,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [srs_pkg::DUTY_W-1:0]    duty_value,
    output logic                          duty_update,
    output logic [srs_pkg::POS_W-1:0]     servo_position,
    output logic [1:0]                    servo_status,
    output logic [1:0]                    recipe_status,

    input  logic                          cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srs_pkg::DUTY_W-1:0]    cfg_data
);

    localparam int AW = $clog2(RECIPE_DEPTH);
    localparam int LOAD_SPAN = 2 ** srs_pkg::ADDR_W;

    // load address to store index, modulo the depth, one entry per address
    function automatic logic [LOAD_SPAN-1:0][AW-1:0] fold_table();
        logic [LOAD_SPAN-1:0][AW-1:0] t;
        for (int i = 0; i < LOAD_SPAN; i++)
        begin
            t[i] = AW'(i % RECIPE_DEPTH);
        end
        return t;
    endfunction

    localparam logic [LOAD_SPAN-1:0][AW-1:0] LOAD_FOLD = fold_table();

    // recipe memory and prefetch register
    logic [srs_pkg::BYTE_W-1:0] recipe_mem [RECIPE_DEPTH];
    logic [srs_pkg::BYTE_W-1:0] rd_byte_reg;

    logic [srs_pkg::DUTY_W-1:0] duty_reg [srs_pkg::NUM_POS];

    logic [AW-1:0]              step_reg, step_next;
    logic [srs_pkg::MOVE_W-1:0] move_cnt_reg, move_cnt_next;
    logic [srs_pkg::PARAM_W-1:0] wait_cnt_reg, wait_cnt_next;
    logic [AW:0]                loop_start_reg, loop_start_next;
    logic [srs_pkg::PARAM_W-1:0] loop_rem_reg, loop_rem_next;
    srs_pkg::run_t              run_reg, run_next;
    srs_pkg::motion_t           motion_reg, motion_next;
    logic [srs_pkg::POS_W-1:0]  pos_reg, pos_next;

    logic                       out_valid_reg;
    logic [srs_pkg::DUTY_W-1:0] duty_value_reg;
    logic                       duty_update_reg;
    logic [srs_pkg::POS_W-1:0]  position_reg;
    logic [1:0]                 servo_status_reg;
    logic [1:0]                 recipe_status_reg;

    logic                       accept;
    logic                       mem_we;
    logic [AW-1:0]              load_idx;
    logic [srs_pkg::OP_W-1:0]   op;
    logic [srs_pkg::PARAM_W-1:0] param;
    logic [AW-1:0]              step_inc;
    logic [AW:0]                loop_body;
    logic [AW-1:0]              loop_jump;
    logic                       mv_en;
    logic [srs_pkg::POS_W-1:0]  mv_tgt;
    logic [srs_pkg::MOVE_W-1:0] mv_dist;
    logic                       moved;
    srs_pkg::run_t              run_ev;
    logic [srs_pkg::DUTY_W-1:0] duty_sel;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign op    = rd_byte_reg[srs_pkg::BYTE_W-1 -: srs_pkg::OP_W];
    assign param = rd_byte_reg[srs_pkg::PARAM_W-1:0];

    assign step_inc  = (step_reg == AW'(RECIPE_DEPTH - 1)) ? '0 : step_reg + 1'b1;
    assign loop_body = {1'b0, step_reg} + 1'b1;
    assign loop_jump = (loop_start_reg == (AW+1)'(RECIPE_DEPTH)) ? '0
                                                               : loop_start_reg[AW-1:0];

    assign load_idx = LOAD_FOLD[load_addr];

    assign mv_dist = (pos_reg > mv_tgt) ? (pos_reg - mv_tgt) : (mv_tgt - pos_reg);

    always_comb
    begin
        step_next       = step_reg;
        move_cnt_next   = move_cnt_reg;
        wait_cnt_next   = wait_cnt_reg;
        loop_start_next = loop_start_reg;
        loop_rem_next   = loop_rem_reg;
        run_next        = run_reg;
        motion_next     = motion_reg;
        pos_next        = pos_reg;
        mem_we          = 1'b0;
        mv_en           = 1'b0;
        mv_tgt          = pos_reg;
        moved           = 1'b0;
        run_ev          = run_reg;

        if (accept)
        begin
            case (mode)
                srs_pkg::MODE_TICK:
                begin
                    if (run_reg != srs_pkg::RS_RUNNING)
                    begin
                        motion_next = srs_pkg::MS_AT_POS;
                    end
                    else
                    begin
                        case (op)
                            srs_pkg::OP_MOVE:
                            begin
                                if (param > 5'(srs_pkg::LAST_POS))
                                begin
                                    run_next = srs_pkg::RS_CMD_ERR;
                                end
                                else if (motion_reg != srs_pkg::MS_MOVING)
                                begin
                                    mv_en  = 1'b1;
                                    mv_tgt = param[srs_pkg::POS_W-1:0];
                                end
                                else if (move_cnt_reg != '0)
                                begin
                                    move_cnt_next = move_cnt_reg - 1'b1;
                                end
                                else
                                begin
                                    motion_next = srs_pkg::MS_AT_POS;
                                    step_next   = step_inc;
                                end
                            end
                            srs_pkg::OP_WAIT:
                            begin
                                if (wait_cnt_reg > 5'd1)
                                begin
                                    wait_cnt_next = wait_cnt_reg - 1'b1;
                                end
                                else if (wait_cnt_reg == 5'd1)
                                begin
                                    wait_cnt_next = '0;
                                    step_next     = step_inc;
                                end
                                else
                                begin
                                    wait_cnt_next = param;
                                end
                            end
                            srs_pkg::OP_LOOP:
                            begin
                                if (loop_start_reg != '0)
                                begin
                                    run_next = srs_pkg::RS_NEST_ERR;
                                end
                                else
                                begin
                                    loop_start_next = loop_body;
                                    loop_rem_next   = param;
                                end
                                step_next = step_inc;
                            end
                            srs_pkg::OP_ENDLOOP:
                            begin
                                if (loop_rem_reg != '0)
                                begin
                                    loop_rem_next = loop_rem_reg - 1'b1;
                                    step_next     = loop_jump;
                                end
                                else
                                begin
                                    loop_start_next = '0;
                                    step_next       = step_inc;
                                end
                            end
                            srs_pkg::OP_END:
                            begin
                                motion_next = srs_pkg::MS_ENDED;
                            end
                            default:
                            begin
                                // unused opcodes hold the step
                            end
                        endcase
                    end
                end
                srs_pkg::MODE_EVENT:
                begin
                    case (event_code)
                        srs_pkg::EV_BEGIN:
                        begin
                            step_next       = '0;
                            loop_start_next = '0;
                            loop_rem_next   = '0;
                            wait_cnt_next   = '0;
                            run_ev          = srs_pkg::RS_RUNNING;
                        end
                        srs_pkg::EV_PAUSE:  run_ev = srs_pkg::RS_PAUSED;
                        srs_pkg::EV_RESUME: run_ev = srs_pkg::RS_RUNNING;
                        default:            run_ev = run_reg;
                    endcase
                    run_next = run_ev;
                    // manual jog only while paused and settled
                    if (run_ev == srs_pkg::RS_PAUSED && motion_reg == srs_pkg::MS_AT_POS)
                    begin
                        if (event_code == srs_pkg::EV_LEFT && pos_reg < srs_pkg::LAST_POS)
                        begin
                            mv_en  = 1'b1;
                            mv_tgt = pos_reg + 1'b1;
                        end
                        else if (event_code == srs_pkg::EV_RIGHT && pos_reg != '0)
                        begin
                            mv_en  = 1'b1;
                            mv_tgt = pos_reg - 1'b1;
                        end
                    end
                end
                srs_pkg::MODE_LOAD:
                begin
                    mem_we = 1'b1;
                end
                default:
                begin
                    // unused mode reports state unchanged
                end
            endcase

            if (mv_en)
            begin
                motion_next   = srs_pkg::MS_MOVING;
                move_cnt_next = mv_dist;
                pos_next      = mv_tgt;
                moved         = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (pos_next)
            3'd0:    duty_sel = duty_reg[0];
            3'd1:    duty_sel = duty_reg[1];
            3'd2:    duty_sel = duty_reg[2];
            3'd3:    duty_sel = duty_reg[3];
            3'd4:    duty_sel = duty_reg[4];
            3'd5:    duty_sel = duty_reg[5];
            default: duty_sel = '0;
        endcase
    end

    // recipe memory: one write port, registered read at the next step index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            recipe_mem[load_idx] <= load_data;
        end
        if (mem_we && load_idx == step_next)
        begin
            rd_byte_reg <= load_data;
        end
        else
        begin
            rd_byte_reg <= recipe_mem[step_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < srs_pkg::NUM_POS; i++)
            begin
                duty_reg[i] <= srs_pkg::DUTY_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srs_pkg::REG_DUTY_POS0: duty_reg[0] <= cfg_data;
                srs_pkg::REG_DUTY_POS1: duty_reg[1] <= cfg_data;
                srs_pkg::REG_DUTY_POS2: duty_reg[2] <= cfg_data;
                srs_pkg::REG_DUTY_POS3: duty_reg[3] <= cfg_data;
                srs_pkg::REG_DUTY_POS4: duty_reg[4] <= cfg_data;
                srs_pkg::REG_DUTY_POS5: duty_reg[5] <= cfg_data;
                default:
                begin
                    // no register at this index
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            move_cnt_reg   <= '0;
            wait_cnt_reg   <= '0;
            loop_start_reg <= '0;
            loop_rem_reg   <= '0;
            run_reg        <= srs_pkg::RS_PAUSED;
            motion_reg     <= srs_pkg::MS_UNKNOWN;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            move_cnt_reg   <= move_cnt_next;
            wait_cnt_reg   <= wait_cnt_next;
            loop_start_reg <= loop_start_next;
            loop_rem_reg   <= loop_rem_next;
            run_reg        <= run_next;
            motion_reg     <= motion_next;
            pos_reg        <= pos_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            duty_value_reg    <= duty_sel;
            duty_update_reg   <= moved;
            position_reg      <= pos_next;
            servo_status_reg  <= motion_next;
            recipe_status_reg <= run_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duty_value     = duty_value_reg;
    assign duty_update    = duty_update_reg;
    assign servo_position = position_reg;
    assign servo_status   = servo_status_reg;
    assign recipe_status  = recipe_status_reg;

endmodule

FILE: hw/rtl/srs_checker.sv
// srs_checker: port-level assertions for servo_recipe_sequencer, bound into that module.
// Depends on srs_pkg for field widths and status codes.

module srs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [srs_pkg::DUTY_W-1:0]    duty_value,
    input logic                          duty_update,
    input logic [srs_pkg::POS_W-1:0]     servo_position,
    input logic [1:0]                    servo_status,
    input logic [1:0]                    recipe_status
);

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(duty_value)
            && $stable(duty_update) && $stable(servo_position)
            && $stable(servo_status) && $stable(recipe_status))
        else $error("result changed while stalled");

    // the input side never stalls while the output register is empty
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> servo_position <= srs_pkg::LAST_POS)
        else $error("servo position out of range");

    // a started move always reports moving
    a_update_moving: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && duty_update |-> servo_status == srs_pkg::MS_MOVING)
        else $error("move started without moving status");

endmodule

bind servo_recipe_sequencer srs_checker u_srs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .duty_value     (duty_value),
    .duty_update    (duty_update),
    .servo_position (servo_position),
    .servo_status   (servo_status),
    .recipe_status  (recipe_status)
);

FILE: bench/tb_top.sv
// tb_top: self-checking bench for servo_recipe_sequencer.
// Depends on srs_pkg and the servo_recipe_sequencer RTL. It predicts every servo
// result in the bench and checks the results in order, with random idle on both sides.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [srs_pkg::MODE_W-1:0]  MODE_SPARE  = 2'd3;
    localparam logic [srs_pkg::EVENT_W-1:0] EV_SPARE_LO = 3'd6;
    localparam logic [srs_pkg::EVENT_W-1:0] EV_SPARE_HI = 3'd7;
    localparam logic [srs_pkg::OP_W-1:0]    OPC_SPARE_A = 3'd3;
    localparam logic [srs_pkg::OP_W-1:0]    OPC_SPARE_B = 3'd6;
    localparam logic [srs_pkg::OP_W-1:0]    OPC_SPARE_C = 3'd7;
    localparam int DUTY_RANDOM = 0;
    localparam int DUTY_ZERO   = 1;
    localparam int DUTY_FULL   = 2;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 280;

    typedef struct packed {
        logic [srs_pkg::MODE_W-1:0]  mode;
        logic [srs_pkg::EVENT_W-1:0] ev;
        logic [srs_pkg::ADDR_W-1:0]  addr;
        logic [srs_pkg::BYTE_W-1:0]  data;
    } servo_cmd_t;

    typedef struct packed {
        logic [srs_pkg::DUTY_W-1:0] duty;
        logic                       upd;
        logic [srs_pkg::POS_W-1:0]  pos;
        logic [1:0]                 servo;
        logic [1:0]                 recipe;
    } servo_view_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [srs_pkg::MODE_W-1:0]  mode;
    logic [srs_pkg::EVENT_W-1:0] event_code;
    logic [srs_pkg::ADDR_W-1:0]  load_addr;
    logic [srs_pkg::BYTE_W-1:0]  load_data;
    logic out_valid;
    logic out_ready;
    logic [srs_pkg::DUTY_W-1:0] duty_value;
    logic duty_update;
    logic [srs_pkg::POS_W-1:0] servo_position;
    logic [1:0] servo_status;
    logic [1:0] recipe_status;
    logic cfg_we;
    logic [srs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [srs_pkg::DUTY_W-1:0] cfg_data;

    servo_recipe_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .event_code     (event_code),
        .load_addr      (load_addr),
        .load_data      (load_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .duty_value     (duty_value),
        .duty_update    (duty_update),
        .servo_position (servo_position),
        .servo_status   (servo_status),
        .recipe_status  (recipe_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // predicted sequencer state
    logic [srs_pkg::BYTE_W-1:0]  recipe_mem [srs_pkg::RECIPE_DEPTH_DEF];
    logic [srs_pkg::DUTY_W-1:0]  duty_tab [srs_pkg::NUM_POS];
    logic [srs_pkg::ADDR_W-1:0]  step_idx = '0;
    int                          move_ticks = 0;
    logic [srs_pkg::PARAM_W-1:0] wait_left = '0;
    logic [srs_pkg::ADDR_W:0]    loop_head = '0;
    logic [srs_pkg::PARAM_W-1:0] loop_passes = '0;
    srs_pkg::run_t               run_st = srs_pkg::RS_PAUSED;
    srs_pkg::motion_t            motion_st = srs_pkg::MS_UNKNOWN;
    logic [srs_pkg::POS_W-1:0]   pos_idx = '0;
    logic                        moved_now;

    servo_cmd_t  cmd_q [$];
    servo_view_t view_q [$];
    int  cmd_count = 0;
    bit  cmd_pending = 1'b0;
    int  cmd_gap = 0;
    int  in_calm = 0;
    int  out_calm = 0;
    int  out_hold = 0;
    int  idle_cycles = 0;
    bit  failed = 1'b0;

    function automatic void start_move(logic [srs_pkg::POS_W-1:0] target);
        motion_st  = srs_pkg::MS_MOVING;
        move_ticks = (pos_idx > target) ? int'(pos_idx - target) : int'(target - pos_idx);
        pos_idx    = target;
        moved_now  = 1'b1;
    endfunction

    function automatic servo_view_t servo_predict(servo_cmd_t c);
        logic [srs_pkg::BYTE_W-1:0]  b;
        logic [srs_pkg::OP_W-1:0]    op;
        logic [srs_pkg::PARAM_W-1:0] prm;
        servo_view_t                 v;
        moved_now = 1'b0;
        if (c.mode == srs_pkg::MODE_TICK)
        begin
            if (run_st != srs_pkg::RS_RUNNING)
            begin
                motion_st = srs_pkg::MS_AT_POS;
            end
            else
            begin
                b   = recipe_mem[step_idx];
                op  = b[srs_pkg::BYTE_W-1 -: srs_pkg::OP_W];
                prm = b[srs_pkg::PARAM_W-1:0];
                case (op)
                    srs_pkg::OP_MOVE:
                    begin
                        if (prm > 5'(srs_pkg::LAST_POS))
                            run_st = srs_pkg::RS_CMD_ERR;
                        else if (motion_st != srs_pkg::MS_MOVING)
                            start_move(prm[srs_pkg::POS_W-1:0]);
                        else if (move_ticks > 0)
                            move_ticks--;
                        else
                        begin
                            motion_st = srs_pkg::MS_AT_POS;
                            step_idx++;
                        end
                    end
                    srs_pkg::OP_WAIT:
                    begin
                        if (wait_left > 5'd1)
                            wait_left--;
                        else if (wait_left == 5'd1)
                        begin
                            wait_left = '0;
                            step_idx++;
                        end
                        else
                            wait_left = prm;
                    end
                    srs_pkg::OP_LOOP:
                    begin
                        if (loop_head != '0)
                            run_st = srs_pkg::RS_NEST_ERR;
                        else
                        begin
                            loop_head   = {1'b0, step_idx} + 1'b1;
                            loop_passes = prm;
                        end
                        step_idx++;
                    end
                    srs_pkg::OP_ENDLOOP:
                    begin
                        if (loop_passes != '0)
                        begin
                            loop_passes--;
                            step_idx = loop_head[srs_pkg::ADDR_W-1:0];
                        end
                        else
                        begin
                            loop_head = '0;
                            step_idx++;
                        end
                    end
                    srs_pkg::OP_END: motion_st = srs_pkg::MS_ENDED;
                    default: ;
                endcase
            end
        end
        else if (c.mode == srs_pkg::MODE_EVENT)
        begin
            if (c.ev == srs_pkg::EV_BEGIN)
            begin
                step_idx    = '0;
                loop_head   = '0;
                loop_passes = '0;
                wait_left   = '0;
                run_st      = srs_pkg::RS_RUNNING;
            end
            if (c.ev == srs_pkg::EV_PAUSE)
                run_st = srs_pkg::RS_PAUSED;
            if (c.ev == srs_pkg::EV_RESUME)
                run_st = srs_pkg::RS_RUNNING;
            if (run_st == srs_pkg::RS_PAUSED && motion_st == srs_pkg::MS_AT_POS)
            begin
                if (c.ev == srs_pkg::EV_LEFT && pos_idx < srs_pkg::LAST_POS)
                    start_move(pos_idx + 1'b1);
                else if (c.ev == srs_pkg::EV_RIGHT && pos_idx != '0)
                    start_move(pos_idx - 1'b1);
            end
        end
        else if (c.mode == srs_pkg::MODE_LOAD)
        begin
            recipe_mem[c.addr] = c.data;
        end
        v.duty   = (pos_idx <= srs_pkg::LAST_POS) ? duty_tab[pos_idx] : '0;
        v.upd    = moved_now;
        v.pos    = pos_idx;
        v.servo  = motion_st;
        v.recipe = run_st;
        return v;
    endfunction

    // short gaps mostly, a few long ones, and now and then a stretch with none
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // ---------------- stimulus builders ----------------
    function automatic servo_cmd_t rand_cmd();
        servo_cmd_t c;
        c.mode = srs_pkg::MODE_W'($urandom_range(0, 3));
        c.ev   = srs_pkg::EVENT_W'($urandom_range(0, 7));
        c.addr = srs_pkg::ADDR_W'($urandom_range(0, 31));
        c.data = srs_pkg::BYTE_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void push_cmd(servo_cmd_t c);
        cmd_q.push_back(c);
        if (c.mode != MODE_SPARE)
            cmd_count++;
    endfunction

    function automatic void push_tick();
        servo_cmd_t c;
        c = rand_cmd();
        c.mode = srs_pkg::MODE_TICK;
        push_cmd(c);
    endfunction

    function automatic void push_event(logic [srs_pkg::EVENT_W-1:0] ev);
        servo_cmd_t c;
        c = rand_cmd();
        c.mode = srs_pkg::MODE_EVENT;
        c.ev   = ev;
        push_cmd(c);
    endfunction

    function automatic void push_load(logic [srs_pkg::ADDR_W-1:0] a,
                                      logic [srs_pkg::BYTE_W-1:0] d);
        servo_cmd_t c;
        c = rand_cmd();
        c.mode = srs_pkg::MODE_LOAD;
        c.addr = a;
        c.data = d;
        push_cmd(c);
    endfunction

    function automatic logic [srs_pkg::BYTE_W-1:0] recipe_byte(logic [srs_pkg::OP_W-1:0] op,
                                                               int prm);
        return {op, prm[srs_pkg::PARAM_W-1:0]};
    endfunction

    function automatic logic [srs_pkg::BYTE_W-1:0] sane_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return recipe_byte(srs_pkg::OP_MOVE, $urandom_range(6, 31));
        if (r < 40)
            return recipe_byte(srs_pkg::OP_MOVE, $urandom_range(0, 5));
        if (r < 65)
            return recipe_byte(srs_pkg::OP_WAIT, $urandom_range(1, 5));
        if (r < 77)
            return recipe_byte(srs_pkg::OP_LOOP, $urandom_range(0, 3));
        if (r < 92)
            return recipe_byte(srs_pkg::OP_ENDLOOP, $urandom_range(0, 31));
        return recipe_byte(srs_pkg::OP_END, $urandom_range(0, 31));
    endfunction

    // load a short recipe at the bottom of the store, start it and tick it along
    function automatic void recipe_run(bit messy);
        int len;
        int r;
        len = $urandom_range(3, 10);
        for (int a = 0; a < len; a++)
            push_load(srs_pkg::ADDR_W'(a),
                      messy ? 8'($urandom_range(0, 255)) : sane_byte());
        if ($urandom_range(0, 3) != 0)
            push_load(srs_pkg::ADDR_W'(len),
                      recipe_byte(srs_pkg::OP_END, $urandom_range(0, 31)));
        push_event(srs_pkg::EV_BEGIN);
        repeat ($urandom_range(10, 70))
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                r = $urandom_range(0, 3);
                if (r == 0)
                begin
                    push_event(srs_pkg::EV_PAUSE);
                    repeat ($urandom_range(0, 3)) push_tick();
                    push_event($urandom_range(0, 1) ? srs_pkg::EV_LEFT : srs_pkg::EV_RIGHT);
                    push_tick();
                    push_event(srs_pkg::EV_RESUME);
                end
                else
                    push_event(srs_pkg::EVENT_W'($urandom_range(0, 7)));
            end
            push_tick();
        end
    endfunction

    // manual jogging while paused, biased to one side to reach the end stops
    function automatic void jog();
        bit go_left;
        go_left = 1'($urandom_range(0, 1));
        push_event(srs_pkg::EV_PAUSE);
        repeat ($urandom_range(3, 12))
        begin
            push_tick();
            push_event((($urandom_range(0, 4) == 0) != go_left) ? srs_pkg::EV_LEFT
                                                                 : srs_pkg::EV_RIGHT);
        end
        if ($urandom_range(0, 1))
            push_event(srs_pkg::EV_RESUME);
    endfunction

    function automatic void noise();
        repeat ($urandom_range(5, 15)) push_cmd(rand_cmd());
    endfunction

    function automatic void run_mix(int n);
        int stop_at;
        int r;
        stop_at = cmd_count + n;
        while (cmd_count < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                recipe_run(1'b0);
            else if (r < 75)
                jog();
            else if (r < 88)
                recipe_run(1'b1);
            else
                noise();
        end
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() != 0 || cmd_pending || view_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_duties(input int style);
        logic [srs_pkg::DUTY_W-1:0] v;
        for (int i = srs_pkg::REG_DUTY_POS0; i <= srs_pkg::REG_DUTY_POS5; i++)
        begin
            if (style == DUTY_ZERO)
                v = '0;
            else if (style == DUTY_FULL)
                v = '1;
            else
                v = srs_pkg::DUTY_W'($urandom_range(0, 255));
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= srs_pkg::cfg_idx_t'(i);
            cfg_data  <= v;
            duty_tab[i] = v;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ---------------- driver ----------------
    always @(negedge clk)
    begin
        servo_cmd_t c;
        if (rst_n && !cmd_pending)
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() != 0)
            begin
                c = cmd_q.pop_front();
                mode        <= c.mode;
                event_code  <= c.ev;
                load_addr   <= c.addr;
                load_data   <= c.data;
                in_valid    <= 1'b1;
                cmd_pending = 1'b1;
                cmd_gap     = pick_gap(in_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_hold > 0)
        begin
            out_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            out_hold = pick_gap(out_calm);
        end
    end

    // ---------------- monitor, checker, watchdog ----------------
    always @(posedge clk)
    begin
        servo_view_t got;
        servo_view_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {duty_value, duty_update, servo_position, servo_status, recipe_status};
                if (view_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: duty=%0d upd=%0d pos=%0d",
                             $time, got.duty, got.upd, got.pos);
                    failed = 1'b1;
                end
                else
                begin
                    want = view_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected duty=%0d upd=%0d pos=%0d srv=%0d rcp=%0d",
                                 $time, want.duty, want.upd, want.pos, want.servo,
                                 want.recipe);
                        $display("%0t: actual   duty=%0d upd=%0d pos=%0d srv=%0d rcp=%0d",
                                 $time, got.duty, got.upd, got.pos, got.servo,
                                 got.recipe);
                        failed = 1'b1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                view_q.push_back(servo_predict({mode, event_code, load_addr, load_data}));
                cmd_pending = 1'b0;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no progress for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = srs_pkg::MODE_TICK;
        event_code = srs_pkg::EV_NONE;
        load_addr  = '0;
        load_data  = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = srs_pkg::REG_DUTY_POS0;
        cfg_data   = '0;
        for (int i = 0; i < srs_pkg::NUM_POS; i++)
            duty_tab[i] = srs_pkg::DUTY_RESET[i];
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_duties(DUTY_RANDOM);

        // every store entry gets written before any recipe runs
        for (int a = 0; a < srs_pkg::RECIPE_DEPTH_DEF; a++)
        begin
            case (a)
                0: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_LOOP, 1));
                1: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_MOVE, 1));
                2: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_ENDLOOP, 0));
                3: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_WAIT, 1));
                4, 5: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_LOOP, 0));
                6: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_MOVE, 31));
                srs_pkg::RECIPE_DEPTH_DEF - 1:
                    push_load(srs_pkg::ADDR_W'(a), recipe_byte(OPC_SPARE_C, 31));
                default: push_load(srs_pkg::ADDR_W'(a), recipe_byte(srs_pkg::OP_END, a));
            endcase
        end

        // directed: idle tick, unused mode and events, manual moves and the right stop
        push_tick();
        push_cmd({MODE_SPARE, EV_SPARE_HI, 5'd31, 8'hFF});
        push_event(srs_pkg::EV_NONE);
        push_event(EV_SPARE_LO);
        push_event(EV_SPARE_HI);
        push_event(srs_pkg::EV_RIGHT);
        push_event(srs_pkg::EV_LEFT);
        push_tick();
        push_event(srs_pkg::EV_RIGHT);
        push_tick();
        // loop with repeated move, wait, then nested loop error and idle ticks
        push_event(srs_pkg::EV_BEGIN);
        repeat (14) push_tick();
        // resume from error lands on the out-of-range move
        push_event(srs_pkg::EV_RESUME);
        push_tick();
        push_tick();
        push_event(srs_pkg::EV_PAUSE);
        push_event(srs_pkg::EV_RESUME);
        // zero wait never advances
        push_load('0, recipe_byte(srs_pkg::OP_WAIT, 0));
        push_event(srs_pkg::EV_BEGIN);
        repeat (3) push_tick();
        // unused opcodes hold the step
        push_load('0, recipe_byte(OPC_SPARE_A, 0));
        push_event(srs_pkg::EV_BEGIN);
        push_tick();
        push_load('0, recipe_byte(OPC_SPARE_B, 0));
        push_tick();
        push_load('0, recipe_byte(OPC_SPARE_C, 0));
        push_tick();
        push_load('0, recipe_byte(srs_pkg::OP_END, 0));
        push_tick();

        run_mix(PHASE_ITEMS);
        wait_idle();
        set_duties(DUTY_ZERO);
        run_mix(PHASE_ITEMS);
        wait_idle();
        set_duties(DUTY_FULL);
        run_mix(PHASE_ITEMS);
        wait_idle();
        set_duties(DUTY_RANDOM);
        run_mix(PHASE_ITEMS);
        wait_idle();
        repeat (4) @(posedge clk);

        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
